// ----- src/bfi_pkg.sv -----
// Shared types, constants and helpers for the Bloom filter block.
`timescale 1ns / 1ps

package bfi_pkg;

    localparam int HASH_W         = 32;
    localparam int MOD_STEP_BITS  = 4;
    localparam int MEM_BYTES_DEF  = 4096;
    localparam int FILTER_BYTES_W = 13;
    localparam int PROBE_W        = 5;
    localparam int BYTE_INDEX_W   = 12;
    localparam int BYTE_W         = 8;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [FILTER_BYTES_W-1:0] FILTER_BYTES_RST = 13'd1024;
    localparam logic [PROBE_W-1:0]        PROBE_COUNT_RST  = 5'd6;
    localparam logic [PROBE_W-1:0]        PROBE_ALWAYS_MAX = 5'd30;

    typedef enum logic [1:0] {
        MODE_CLEAR,
        MODE_INSERT,
        MODE_QUERY,
        MODE_READ
    } bfi_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_BYTES,
        CFG_PROBE_COUNT
    } bfi_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOD,
        ST_PROBE,
        ST_READ
    } bfi_state_t;

    typedef struct packed {
        bfi_mode_t                 mode;
        logic [HASH_W-1:0]         key_hash;
        logic [BYTE_INDEX_W-1:0]   byte_index;
    } bfi_req_t;

    typedef struct packed {
        logic              may_match;
        logic [BYTE_W-1:0] byte_value;
    } bfi_rsp_t;

    // Probe stride: key hash rotated left by 15.
    function automatic logic [HASH_W-1:0] bfi_rot15(input logic [HASH_W-1:0] h);
        return {h[HASH_W-16:0], h[HASH_W-1:HASH_W-15]};
    endfunction

endpackage

// ----- src/bfi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read of the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/bfi_mod.sv -----
// Iterative remainder unit: 32-bit dividend modulo a narrow divisor.
`timescale 1ns / 1ps

module bfi_mod #(
    parameter int DIV_W = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bfi_pkg::HASH_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           remainder
);

    import bfi_pkg::*;

    localparam int STEPS = HASH_W / MOD_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W:0]    step_rem;
    logic [HASH_W-1:0] step_dvd;

    // Restoring remainder, several dividend bits per cycle; rem stays below divisor.
    always_comb
    begin
        step_rem = {1'b0, rem_reg};
        step_dvd = dvd_reg;
        for (int i = 0; i < MOD_STEP_BITS; i++)
        begin
            step_rem = {step_rem[DIV_W-1:0], step_dvd[HASH_W-1]};
            step_dvd = {step_dvd[HASH_W-2:0], 1'b0};
            if (step_rem >= {1'b0, div_reg})
            begin
                step_rem = step_rem - {1'b0, div_reg};
            end
        end
        rem_next = step_rem[DIV_W-1:0];
        dvd_next = step_dvd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(STEPS - 1);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            run_reg  <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/bloom_filter_insert_query.sv -----
// Top level of the Bloom filter: control, probe datapath and bit-array RAM.
//
//   channel  | handshake        | payload                           | note
//   ---------+------------------+-----------------------------------+---------------------
//   request  | start / busy     | req: mode, key_hash, byte_index   | taken on start & !busy
//   result   | done (1 cycle)   | rsp: may_match, byte_value        | one per request
//   config   | cfg_we           | cfg_index, cfg_data               | write-only, no wait
//
// Insert/query: three remainder units take 4 hash bits per cycle, then one probe per cycle
//   through the single RAM read port.
// Read byte: RAM read in ST_IDLE, byte returned from ST_READ. Clear: one byte per cycle.
// After reset a clearing pass over all MEM_BYTES bytes runs with busy high and no result.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps

module bloom_filter_insert_query #(
    parameter int MEM_BYTES = bfi_pkg::MEM_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bfi_pkg::bfi_req_t               req,
    output logic                            done,
    output bfi_pkg::bfi_rsp_t               rsp,
    input  logic                            cfg_we,
    input  logic [bfi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfi_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bfi_pkg::*;

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int NB_W = $clog2(MEM_BYTES + 1);
    localparam int BW   = NB_W + 3;

    bfi_state_t state_reg, state_next;

    logic [FILTER_BYTES_W-1:0] filter_bytes_reg;
    logic [PROBE_W-1:0]        probe_count_reg;

    logic [NB_W-1:0]   used_bytes;
    logic [BW-1:0]     bits;
    logic              accept;
    logic              in_range;
    logic [HASH_W-1:0] idx_ext;
    logic [HASH_W-1:0] delta_in;
    logic [HASH_W-1:0] wrap_dvd;
    logic              fast_done, fast_match, need_mod;

    logic [AW-1:0]      clr_reg, clr_next;
    logic               clr_reply_reg, clr_reply_next;
    logic               is_query_reg, is_query_next;
    logic [HASH_W-1:0]  h_reg, h_next;
    logic [HASH_W-1:0]  delta_reg, delta_next;
    logic [BW-1:0]      pos_reg, pos_next;
    logic [BW-1:0]      dmod_reg, dmod_next;
    logic [BW-1:0]      wmod_reg, wmod_next;
    logic [PROBE_W-1:0] iss_reg, iss_next;
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_last_reg, s2_last_next;
    logic [AW-1:0]      s2_addr_reg, s2_addr_next;
    logic [2:0]         s2_bit_reg, s2_bit_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]      fwd_addr_reg, fwd_addr_next;
    logic [BYTE_W-1:0]  fwd_data_reg, fwd_data_next;
    logic               done_reg, done_next;
    bfi_rsp_t           rsp_reg, rsp_next;

    logic [2:0]         mod_done;
    logic               mod_start;
    logic [BW-1:0]      rem_h, rem_d, rem_w;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    logic [HASH_W:0]   h_sum;
    logic              h_carry;
    logic [BW+1:0]     pos_sum, pos_adj;
    logic [BYTE_W-1:0] s2_cur, s2_merged;
    logic              s2_hit;
    logic              in_probe, issue, s2_go, finish, clear_last;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bytes_reg <= FILTER_BYTES_RST;
            probe_count_reg  <= PROBE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (bfi_cfg_idx_t'(cfg_index))
                CFG_FILTER_BYTES: filter_bytes_reg <= cfg_data[FILTER_BYTES_W-1:0];
                CFG_PROBE_COUNT:  probe_count_reg  <= cfg_data[PROBE_W-1:0];
            endcase
        end
    end

    assign used_bytes = (HASH_W'(filter_bytes_reg) > HASH_W'(MEM_BYTES))
                      ? NB_W'(MEM_BYTES) : NB_W'(filter_bytes_reg);
    assign bits       = {used_bytes, 3'b000};

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign idx_ext  = HASH_W'(req.byte_index);
    assign in_range = idx_ext < HASH_W'(MEM_BYTES);
    assign delta_in = bfi_rot15(req.key_hash);
    // 2^32 - bits has the same remainder as 2^32 (bits is at least 8 when used)
    assign wrap_dvd = HASH_W'(0) - HASH_W'(bits);

    // Requests that finish without touching the array.
    always_comb
    begin
        fast_done  = 1'b0;
        fast_match = 1'b0;
        need_mod   = 1'b0;
        unique case (req.mode)
            MODE_CLEAR:
            begin
                fast_done = 1'b0;
            end
            MODE_INSERT:
            begin
                if (used_bytes == '0 || probe_count_reg == '0)
                begin
                    fast_done = 1'b1;
                end
                else
                begin
                    need_mod = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                priority if (used_bytes == '0)
                begin
                    fast_done = 1'b1;
                end
                else if (probe_count_reg > PROBE_ALWAYS_MAX || probe_count_reg == '0)
                begin
                    fast_done  = 1'b1;
                    fast_match = 1'b1;
                end
                else
                begin
                    need_mod = 1'b1;
                end
            end
            MODE_READ:
            begin
                fast_done = !in_range;
            end
        endcase
    end

    // ---------------- remainder units ----------------
    assign mod_start = accept && need_mod;

    bfi_mod #(.DIV_W(BW)) u_mod_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req.key_hash),
        .divisor   (bits),
        .done      (mod_done[0]),
        .remainder (rem_h)
    );

    bfi_mod #(.DIV_W(BW)) u_mod_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (delta_in),
        .divisor   (bits),
        .done      (mod_done[1]),
        .remainder (rem_d)
    );

    bfi_mod #(.DIV_W(BW)) u_mod_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (wrap_dvd),
        .divisor   (bits),
        .done      (mod_done[2]),
        .remainder (rem_w)
    );

    // ---------------- probe datapath ----------------
    // Advance the bit position incrementally; a 32-bit wrap of the hash removes 2^32 mod bits.
    assign h_sum   = {1'b0, h_reg} + {1'b0, delta_reg};
    assign h_carry = h_sum[HASH_W];
    assign pos_sum = {2'b00, pos_reg} + {2'b00, dmod_reg}
                   - (h_carry ? {2'b00, wmod_reg} : '0);

    always_comb
    begin
        priority if (pos_sum[BW+1])
        begin
            pos_adj = pos_sum + {2'b00, bits};
        end
        else if (pos_sum >= {2'b00, bits})
        begin
            pos_adj = pos_sum - {2'b00, bits};
        end
        else
        begin
            pos_adj = pos_sum;
        end
    end

    // Forward the previous write: the RAM read of the next probe misses it.
    assign s2_cur    = (fwd_valid_reg && fwd_addr_reg == s2_addr_reg) ? fwd_data_reg
                                                                      : ram_rdata;
    assign s2_hit    = s2_cur[s2_bit_reg];
    assign s2_merged = s2_cur | (BYTE_W'(1) << s2_bit_reg);

    assign in_probe   = (state_reg == ST_PROBE);
    assign issue      = in_probe && (iss_reg != probe_count_reg);
    assign s2_go      = in_probe && s2_valid_reg;
    assign finish     = s2_go && (s2_last_reg || (is_query_reg && !s2_hit));
    assign clear_last = (clr_reg == AW'(MEM_BYTES - 1));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.mode)
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        MODE_INSERT: state_next = need_mod ? ST_MOD : ST_IDLE;
                        MODE_QUERY:  state_next = need_mod ? ST_MOD : ST_IDLE;
                        MODE_READ:   state_next = in_range ? ST_READ : ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (mod_done[0])
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb
    begin
        clr_next       = clr_reg;
        clr_reply_next = clr_reply_reg;
        is_query_next  = is_query_reg;
        h_next         = h_reg;
        delta_next     = delta_reg;
        pos_next       = pos_reg;
        dmod_next      = dmod_reg;
        wmod_next      = wmod_reg;
        iss_next       = iss_reg;
        s2_valid_next  = 1'b0;
        s2_last_next   = s2_last_reg;
        s2_addr_next   = s2_addr_reg;
        s2_bit_next    = s2_bit_reg;
        fwd_valid_next = 1'b0;
        fwd_addr_next  = s2_addr_reg;
        fwd_data_next  = s2_merged;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = s2_addr_reg;
        ram_wdata      = s2_merged;
        ram_raddr      = pos_reg[AW+2:3];

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = idx_ext[AW-1:0];
                if (accept)
                begin
                    is_query_next  = (req.mode == MODE_QUERY);
                    h_next         = req.key_hash;
                    delta_next     = delta_in;
                    clr_next       = '0;
                    clr_reply_next = 1'b1;
                    if (fast_done)
                    begin
                        done_next          = 1'b1;
                        rsp_next.may_match  = fast_match;
                        rsp_next.byte_value = '0;
                    end
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clear_last)
                begin
                    done_next = clr_reply_reg;
                    rsp_next  = '0;
                end
            end
            ST_MOD:
            begin
                if (mod_done[0])
                begin
                    pos_next  = rem_h;
                    dmod_next = rem_d;
                    wmod_next = rem_w;
                    iss_next  = '0;
                end
            end
            ST_PROBE:
            begin
                if (issue)
                begin
                    pos_next     = pos_adj[BW-1:0];
                    h_next       = h_sum[HASH_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                    s2_addr_next = pos_reg[AW+2:3];
                    s2_bit_next  = pos_reg[2:0];
                    s2_last_next = (iss_reg == PROBE_W'(probe_count_reg - 1'b1));
                end
                s2_valid_next = issue && !finish;
                if (s2_go && !is_query_reg)
                begin
                    ram_we         = 1'b1;
                    fwd_valid_next = 1'b1;
                end
                if (finish)
                begin
                    done_next           = 1'b1;
                    rsp_next.may_match  = is_query_reg && s2_hit;
                    rsp_next.byte_value = '0;
                end
            end
            ST_READ:
            begin
                done_next           = 1'b1;
                rsp_next.may_match  = 1'b0;
                rsp_next.byte_value = ram_rdata;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    // Reset starts the clearing pass with no result owed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            iss_reg       <= '0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_reply_reg <= clr_reply_next;
            iss_reg       <= iss_next;
            s2_valid_reg  <= s2_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_query_reg <= is_query_next;
        h_reg        <= h_next;
        delta_reg    <= delta_next;
        pos_reg      <= pos_next;
        dmod_reg     <= dmod_next;
        wmod_reg     <= wmod_next;
        s2_last_reg  <= s2_last_next;
        s2_addr_reg  <= s2_addr_next;
        s2_bit_reg   <= s2_bit_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        rsp_reg      <= rsp_next;
    end

    bfi_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor answered");

    a_mod_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done[0] |-> (mod_done[1] && mod_done[2]))
        else $error("remainder units out of step");

    a_pos_in_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (pos_reg < bits))
        else $error("probe position outside filter");

    a_probe_byte_in_filter: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (HASH_W'(s2_addr_reg) < HASH_W'(used_bytes)))
        else $error("probed byte outside used array");
`endif

endmodule

// ----- test/tb_bloom_filter_insert_query.sv -----
// Testbench for the Bloom filter block: directed and random requests against a shadow filter.
`timescale 1ns / 1ps

module tb_bloom_filter_insert_query;

    import bfi_pkg::*;

    localparam int MEM_SIZE    = MEM_BYTES_DEF;
    localparam int MEM_AW      = $clog2(MEM_SIZE);
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 82;
    localparam int POOL_DEPTH  = 64;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    bfi_req_t                req;
    logic                    done;
    bfi_rsp_t                rsp;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Shadow copy of the filter state and its registers
    logic [BYTE_W-1:0]         shadow_bytes [0:MEM_SIZE-1];
    logic [FILTER_BYTES_W-1:0] shadow_filter_bytes;
    logic [PROBE_W-1:0]        shadow_probe_count;

    bfi_rsp_t    pending_answers [$];
    bfi_rsp_t    want;
    logic [31:0] key_pool [$];
    bit          back_to_back;
    int          error_count;
    int          requests_sent;
    int          clears_sent;
    int          answers_checked;
    int          maybe_answers;
    int          settings_used;
    int          cycle_count;

    bloom_filter_insert_query dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Work out the answer to one request and update the shadow array.
    function automatic bfi_rsp_t filter_answer(input bfi_req_t r);
        bfi_rsp_t    ans;
        logic [31:0] h;
        logic [31:0] stride;
        logic [31:0] nbits;
        logic [31:0] pos;
        int unsigned nbytes;
        ans    = '0;
        nbytes = (int'(shadow_filter_bytes) > MEM_SIZE) ? MEM_SIZE : int'(shadow_filter_bytes);
        nbits  = nbytes * 8;
        h      = r.key_hash;
        stride = {h[16:0], h[31:17]};
        case (r.mode)
            MODE_CLEAR:
            begin
                foreach (shadow_bytes[i])
                    shadow_bytes[i] = '0;
            end
            MODE_INSERT:
            begin
                if (nbytes != 0)
                begin
                    for (int j = 0; j < int'(shadow_probe_count); j++)
                    begin
                        pos = h % nbits;
                        shadow_bytes[pos[MEM_AW+2:3]][pos[2:0]] = 1'b1;
                        h = h + stride;
                    end
                end
            end
            MODE_QUERY:
            begin
                // an empty filter wins over the many-probes rule
                if (nbytes == 0)
                    ans.may_match = 1'b0;
                else if (shadow_probe_count > PROBE_ALWAYS_MAX)
                    ans.may_match = 1'b1;
                else
                begin
                    ans.may_match = 1'b1;
                    for (int j = 0; j < int'(shadow_probe_count); j++)
                    begin
                        pos = h % nbits;
                        if (!shadow_bytes[pos[MEM_AW+2:3]][pos[2:0]])
                        begin
                            ans.may_match = 1'b0;
                            break;
                        end
                        h = h + stride;
                    end
                end
            end
            default:
            begin
                if (int'(r.byte_index) < MEM_SIZE)
                    ans.byte_value = shadow_bytes[r.byte_index];
            end
        endcase
        return ans;
    endfunction

    // Compare each result with the oldest outstanding answer.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, actual may_match %0b byte_value %0h",
                         $time, rsp.may_match, rsp.byte_value);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (rsp.may_match !== want.may_match)
                begin
                    $display("%0t: may_match mismatch, expected %0b actual %0b",
                             $time, want.may_match, rsp.may_match);
                    error_count++;
                end
                if (rsp.byte_value !== want.byte_value)
                begin
                    $display("%0t: byte_value mismatch, expected %0h actual %0h",
                             $time, want.byte_value, rsp.byte_value);
                    error_count++;
                end
                if (rsp.may_match === 1'b1)
                    maybe_answers++;
            end
        end
    end

    // Send one request; start stays high across back-to-back requests.
    task automatic send_request(input bfi_mode_t m, input logic [31:0] key,
                                input logic [BYTE_INDEX_W-1:0] idx);
        bfi_req_t r;
        int       gap;
        r.mode       = m;
        r.key_hash   = key;
        r.byte_index = idx;
        gap = back_to_back ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_answers.push_back(filter_answer(r));
        requests_sent++;
        if (m == MODE_CLEAR)
            clears_sent++;
    endtask

    // Drop start and hold until every answer is back and the block is idle.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input bfi_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FILTER_BYTES)
            shadow_filter_bytes = value;
        else
            shadow_probe_count = value[PROBE_W-1:0];
    endtask

    task automatic set_filter(input logic [CFG_DATA_W-1:0] nbytes,
                              input logic [CFG_DATA_W-1:0] probes);
        write_reg(CFG_FILTER_BYTES, nbytes);
        write_reg(CFG_PROBE_COUNT, probes);
        settings_used++;
    endtask

    // Reset values: empty array, 1024 bytes, six probes.
    task automatic test_defaults();
        send_request(MODE_QUERY, 32'h0000_0000, '0);
        send_request(MODE_INSERT, 32'h0000_0000, '0);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, '0);
        send_request(MODE_QUERY, 32'hFFFF_FFFF, '0);
        send_request(MODE_QUERY, 32'h0000_0000, '0);
        send_request(MODE_READ, 32'h0000_0000, 12'd0);
        send_request(MODE_READ, 32'hFFFF_FFFF, 12'hFFF);
    endtask

    task automatic test_clear();
        send_request(MODE_CLEAR, 32'h1234_5678, 12'hABC);
        send_request(MODE_READ, 32'h0, 12'd0);
        send_request(MODE_QUERY, 32'hFFFF_FFFF, 12'h555);
    endtask

    task automatic test_probe_extremes();
        set_filter(13'd1024, 13'd0);
        send_request(MODE_INSERT, 32'h1234_5678, '0);
        send_request(MODE_QUERY, 32'hDEAD_BEEF, '0);
        set_filter(13'd1024, 13'd31);
        // with this many probes a query answers yes without looking
        send_request(MODE_QUERY, 32'hCAFE_F00D, '0);
        send_request(MODE_INSERT, 32'h0BAD_F00D, '0);
        set_filter(13'd1024, 13'd30);
        send_request(MODE_QUERY, 32'h0BAD_F00D, '0);
        send_request(MODE_QUERY, 32'h1357_9BDF, '0);
    endtask

    task automatic test_filter_size();
        set_filter(13'd0, 13'd31);
        send_request(MODE_INSERT, 32'hA5A5_A5A5, '0);
        send_request(MODE_QUERY, 32'hA5A5_A5A5, '0);
        set_filter(13'd1, 13'd4);
        send_request(MODE_INSERT, 32'h5A5A_5A5A, '0);
        send_request(MODE_READ, 32'h0, 12'd0);
        send_request(MODE_QUERY, 32'h5A5A_5A5A, '0);
        set_filter(13'h1FFF, 13'd12);
        send_request(MODE_INSERT, 32'h7FFF_FFFF, '0);
        send_request(MODE_QUERY, 32'h7FFF_FFFF, '0);
        send_request(MODE_READ, 32'h0, 12'hFFF);
        // a clear wipes the whole array even when the filter is tiny
        set_filter(13'd1, 13'd4);
        send_request(MODE_CLEAR, 32'h0, '0);
        send_request(MODE_READ, 32'h7FFF_FFFF, 12'hFFF);
    endtask

    // Mostly insert-then-query traffic on recent keys, with reads and some noise.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] nbytes;
        logic [CFG_DATA_W-1:0] probes;
        logic [31:0]           key;
        int unsigned           used;
        int                    pick;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin nbytes = 13'd1024; probes = 13'd6;  end
                1:       begin nbytes = 13'd1;    probes = 13'd2;  end
                2:       begin nbytes = 13'd3;    probes = 13'd7;  end
                3:       begin nbytes = 13'd4096; probes = 13'd31; end
                4:       begin nbytes = 13'h1FFF; probes = 13'd1;  end
                5:       begin nbytes = 13'd0;    probes = 13'd5;  end
                6:       begin nbytes = 13'd37;   probes = 13'd0;  end
                default:
                begin
                    nbytes = ($urandom_range(0, 3) == 0)
                           ? CFG_DATA_W'($urandom_range(0, 8191))
                           : CFG_DATA_W'($urandom_range(1, 512));
                    probes = CFG_DATA_W'($urandom_range(0, 31));
                end
            endcase
            set_filter(nbytes, probes);
            back_to_back = (p % 3 == 1);
            used = (int'(nbytes) > MEM_SIZE) ? MEM_SIZE : int'(nbytes);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                begin
                    send_request(MODE_CLEAR, $urandom,
                                 BYTE_INDEX_W'($urandom_range(0, 4095)));
                    key_pool.delete();
                end
                else if (pick < 40)
                begin
                    key = $urandom;
                    send_request(MODE_INSERT, key, BYTE_INDEX_W'($urandom_range(0, 4095)));
                    if (key_pool.size() >= POOL_DEPTH)
                        void'(key_pool.pop_front());
                    key_pool.push_back(key);
                end
                else if (pick < 75)
                begin
                    if (key_pool.size() != 0 && $urandom_range(0, 9) < 6)
                        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        key = $urandom;
                    send_request(MODE_QUERY, key, BYTE_INDEX_W'($urandom_range(0, 4095)));
                end
                else if (pick < 95)
                begin
                    // aim reads mostly at the part of the array in use
                    if (used != 0 && $urandom_range(0, 1) == 0)
                        send_request(MODE_READ, $urandom,
                                     BYTE_INDEX_W'($urandom_range(0, used - 1)));
                    else
                        send_request(MODE_READ, $urandom,
                                     BYTE_INDEX_W'($urandom_range(0, 4095)));
                end
                else
                    send_request(bfi_mode_t'($urandom_range(0, 3)), $urandom,
                                 BYTE_INDEX_W'($urandom_range(0, 4095)));
                // switch back-to-back runs on or off now and then inside a phase too
                if (n % 20 == 19)
                    back_to_back = ($urandom_range(0, 3) == 0);
            end
        end
        back_to_back = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        start               = 1'b0;
        req                 = '0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        back_to_back        = 1'b0;
        error_count         = 0;
        requests_sent       = 0;
        clears_sent         = 0;
        answers_checked     = 0;
        maybe_answers       = 0;
        settings_used       = 0;
        cycle_count         = 0;
        shadow_filter_bytes = FILTER_BYTES_RST;
        shadow_probe_count  = PROBE_COUNT_RST;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the power-on clearing pass is over
        wait_quiet();

        test_defaults();
        test_clear();
        test_probe_extremes();
        test_filter_size();
        test_random_traffic();

        wait_quiet();
        repeat (20) @(posedge clk);

        $display("covered %0d requests (%0d clears) over %0d filter settings",
                 requests_sent, clears_sent, settings_used);
        $display("checked %0d answers, %0d of them maybe-present, %0d errors",
                 answers_checked, maybe_answers, error_count);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
